>>> sv/vn2d_pkg.sv
`timescale 1ns / 1ps

package vn2d_pkg;

  localparam int COORD_W  = 32;
  localparam int NOISE_W  = 18;

  localparam logic [31:0] X_OFFSET   = 32'd256;
  localparam logic [31:0] Y_OFFSET   = 32'd4096;
  localparam logic [31:0] ROW_STRIDE = 32'd11;

  localparam logic [31:0] HASH_MUL  = 32'd15731;
  localparam logic [31:0] HASH_ADD1 = 32'd789221;
  localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
  localparam logic [31:0] HASH_MASK = 32'h7FFF_FFFF;

  localparam int SPLIT_LAT  = 3;
  localparam int SMOOTH_LAT = 2;
  localparam int HASH_LAT   = 4;
  localparam int BLEND_LAT  = 6;
  localparam int PIPE_LAT   = SPLIT_LAT + HASH_LAT + BLEND_LAT;
  localparam int SHAPE_DLY  = SPLIT_LAT + HASH_LAT - SMOOTH_LAT;

endpackage

>>> sv/vn2d_in_if.sv
`timescale 1ns / 1ps

interface vn2d_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vn2d_pkg::COORD_W-1:0]    x_coord;
  logic signed [vn2d_pkg::COORD_W-1:0]    y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

>>> sv/vn2d_out_if.sv
`timescale 1ns / 1ps

interface vn2d_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vn2d_pkg::NOISE_W-1:0]    noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

>>> sv/vn2d_split.sv
`timescale 1ns / 1ps

module vn2d_split #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [vn2d_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [vn2d_pkg::COORD_W-1:0]  y_coord,
  output logic [31:0]                          n00,
  output logic [31:0]                          n10,
  output logic [31:0]                          n01,
  output logic [31:0]                          n11
);
  import vn2d_pkg::*;

  logic signed [COORD_W-1:0] xs;
  logic signed [COORD_W-1:0] ys;
  logic [31:0] xc;
  logic [31:0] yc;
  logic [31:0] base;
  logic [31:0] i10;
  logic [31:0] i01;
  logic [31:0] i11;

  assign xs = x_coord >>> FRAC_BITS;
  assign ys = y_coord >>> FRAC_BITS;

  assign i10 = base + 32'd1;
  assign i01 = base + ROW_STRIDE;
  assign i11 = base + ROW_STRIDE + 32'd1;

  // cells, then lattice base, then pre-hash mix of each corner
  always_ff @(posedge clk) begin
    if (en) begin
      xc   <= 32'(xs) + X_OFFSET;
      yc   <= 32'(ys) + Y_OFFSET;
      base <= xc + 32'(yc * ROW_STRIDE);
      n00  <= (base << 13) ^ base;
      n10  <= (i10 << 13) ^ i10;
      n01  <= (i01 << 13) ^ i01;
      n11  <= (i11 << 13) ^ i11;
    end
  end

endmodule

>>> sv/vn2d_smooth.sv
`timescale 1ns / 1ps

module vn2d_smooth #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [FRAC_BITS-1:0]  frac,
  output logic [FRAC_BITS:0]    shape
);

  localparam logic [FRAC_BITS+1:0] THREE = (FRAC_BITS+2)'(3) << FRAC_BITS;

  logic [2*FRAC_BITS-1:0] ff;
  logic [FRAC_BITS-1:0]   f2;
  logic [FRAC_BITS+1:0]   w;
  logic [2*FRAC_BITS+1:0] prod;

  assign ff   = (2*FRAC_BITS)'(frac) * (2*FRAC_BITS)'(frac);
  assign prod = (2*FRAC_BITS+2)'(f2) * (2*FRAC_BITS+2)'(w);

  // 3f^2 - 2f^3 as f^2 * (3 - 2f)
  always_ff @(posedge clk) begin
    if (en) begin
      f2    <= ff[2*FRAC_BITS-1:FRAC_BITS];
      w     <= THREE - {1'b0, frac, 1'b0};
      shape <= prod[2*FRAC_BITS:FRAC_BITS];
    end
  end

endmodule

>>> sv/vn2d_hash.sv
`timescale 1ns / 1ps

module vn2d_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [31:0]                  n_in,
  output logic signed [FRAC_BITS:0]    corner
);
  import vn2d_pkg::*;

  logic [31:0] n1;
  logic [31:0] n2;
  logic [31:0] nn;
  logic [31:0] p;
  logic [31:0] q;
  logic [31:0] h;

  assign h = (q + HASH_ADD2) & HASH_MASK;

  // n*(n*n*a + b) + c, at most one multiply per stage
  always_ff @(posedge clk) begin
    if (en) begin
      nn     <= 32'(n_in * n_in);
      n1     <= n_in;
      p      <= 32'(nn * HASH_MUL) + HASH_ADD1;
      n2     <= n1;
      q      <= 32'(p * n2);
      corner <= $signed({~h[30], h[29:30-FRAC_BITS]});
    end
  end

endmodule

>>> sv/vn2d_blend.sv
`timescale 1ns / 1ps

module vn2d_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [FRAC_BITS:0]            v00,
  input  logic signed [FRAC_BITS:0]            v10,
  input  logic signed [FRAC_BITS:0]            v01,
  input  logic signed [FRAC_BITS:0]            v11,
  input  logic [FRAC_BITS:0]                   sx,
  input  logic [FRAC_BITS:0]                   sy,
  output logic signed [vn2d_pkg::NOISE_W-1:0]  noise
);
  import vn2d_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int EXT_W = (F + 3 > NOISE_W) ? F + 3 : NOISE_W;

  // row stage
  logic signed [F:0]     a0_1, a1_1;
  logic signed [F+1:0]   dx0, dx1;
  logic [F:0]            sx1, sy1;
  logic signed [F:0]     a0_2, a1_2;
  logic signed [2*F+3:0] p0, p1;
  logic [F:0]            sy2;
  logic signed [F+1:0]   c3, d3;
  logic [F:0]            sy3;
  // column stage
  logic signed [F+2:0]   dd;
  logic signed [F+1:0]   c4;
  logic [F:0]            sy4;
  logic signed [2*F+5:0] pc;
  logic signed [F+1:0]   c5;

  logic signed [2*F+3:0] sh0, sh1;
  logic signed [2*F+5:0] shc;
  logic signed [F+1:0]   a0x, a1x;
  logic signed [F+2:0]   c5x;
  logic signed [F+2:0]   r_full;
  logic signed [EXT_W-1:0] r_ext;

  assign sh0    = p0 >>> F;
  assign sh1    = p1 >>> F;
  assign shc    = pc >>> F;
  assign a0x    = (F+2)'(a0_2);
  assign a1x    = (F+2)'(a1_2);
  assign c5x    = (F+3)'(c5);
  assign r_full = c5x + $signed(shc[F+2:0]);
  assign r_ext  = EXT_W'(r_full);

  always_ff @(posedge clk) begin
    if (en) begin
      dx0   <= (F+2)'(v10) - (F+2)'(v00);
      dx1   <= (F+2)'(v11) - (F+2)'(v01);
      a0_1  <= v00;
      a1_1  <= v01;
      sx1   <= sx;
      sy1   <= sy;

      p0    <= (2*F+4)'(dx0) * (2*F+4)'($signed({1'b0, sx1}));
      p1    <= (2*F+4)'(dx1) * (2*F+4)'($signed({1'b0, sx1}));
      a0_2  <= a0_1;
      a1_2  <= a1_1;
      sy2   <= sy1;

      c3    <= a0x + $signed(sh0[F+1:0]);
      d3    <= a1x + $signed(sh1[F+1:0]);
      sy3   <= sy2;

      dd    <= (F+3)'(d3) - (F+3)'(c3);
      c4    <= c3;
      sy4   <= sy3;

      pc    <= (2*F+6)'(dd) * (2*F+6)'($signed({1'b0, sy4}));
      c5    <= c4;

      noise <= r_ext[NOISE_W-1:0];
    end
  end

endmodule

>>> sv/value_noise_2d.sv
`timescale 1ns / 1ps

// 2d lattice value noise: takes a signed q16.16 x/y pair, returns one signed q1.16 sample
// per item. fully pipelined, one item per cycle; depth is set by the coordinate split,
// the four-stage corner hash (three chained 32-bit multiplies) and the two
// multiply-and-add blend passes. a stall on the output freezes the whole pipeline, so
// in.ready is low only while a result waits and out.ready is low. coordinates must keep
// x >= -256.0 and y >= -4096.0.
module value_noise_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  vn2d_in_if.sink     in_ch,
  vn2d_out_if.source  out_ch
);
  import vn2d_pkg::*;

  logic                    en;
  logic [PIPE_LAT-1:0]     vld;
  logic [31:0]             n00, n10, n01, n11;
  logic signed [FRAC_BITS:0] v00, v10, v01, v11;
  logic [FRAC_BITS:0]      sx, sy;
  logic [FRAC_BITS:0]      sx_dly [SHAPE_DLY];
  logic [FRAC_BITS:0]      sy_dly [SHAPE_DLY];

  assign en           = !vld[PIPE_LAT-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_ch.valid};
    end
  end

  vn2d_split #(.FRAC_BITS(FRAC_BITS)) u_split (
    .clk     (clk),
    .en      (en),
    .x_coord (in_ch.x_coord),
    .y_coord (in_ch.y_coord),
    .n00     (n00),
    .n10     (n10),
    .n01     (n01),
    .n11     (n11)
  );

  vn2d_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_x (
    .clk   (clk),
    .en    (en),
    .frac  (in_ch.x_coord[FRAC_BITS-1:0]),
    .shape (sx)
  );

  vn2d_smooth #(.FRAC_BITS(FRAC_BITS)) u_smooth_y (
    .clk   (clk),
    .en    (en),
    .frac  (in_ch.y_coord[FRAC_BITS-1:0]),
    .shape (sy)
  );

  // align the shaped fractions with the corner values
  always_ff @(posedge clk) begin
    if (en) begin
      sx_dly[0] <= sx;
      sy_dly[0] <= sy;
      for (int i = 1; i < SHAPE_DLY; i++) begin
        sx_dly[i] <= sx_dly[i-1];
        sy_dly[i] <= sy_dly[i-1];
      end
    end
  end

  vn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash00 (
    .clk (clk), .en (en), .n_in (n00), .corner (v00)
  );
  vn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash10 (
    .clk (clk), .en (en), .n_in (n10), .corner (v10)
  );
  vn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash01 (
    .clk (clk), .en (en), .n_in (n01), .corner (v01)
  );
  vn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash11 (
    .clk (clk), .en (en), .n_in (n11), .corner (v11)
  );

  vn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk   (clk),
    .en    (en),
    .v00   (v00),
    .v10   (v10),
    .v01   (v01),
    .v11   (v11),
    .sx    (sx_dly[SHAPE_DLY-1]),
    .sy    (sy_dly[SHAPE_DLY-1]),
    .noise (out_ch.noise_value)
  );

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted item not in first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input blocked with no waiting result");

endmodule
